### design/lspfe_pkg.sv
package lspfe_pkg;

	// Field widths.
	localparam int OP_W      = 3;
	localparam int IDX_W     = 16;
	localparam int COORD_W   = 16;
	localparam int WORD_W    = 32;
	localparam int COLOR_W   = 29;
	localparam int RGB_W     = 24;
	localparam int BRIGHT_W  = 5;
	localparam int BYTE_W    = 8;
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 2;
	localparam int TYPE_W    = 2;
	localparam int SECT_W    = 2;
	localparam int SUB_W     = 4;

	// Opcodes.
	localparam logic [OP_W-1:0] OP_SET_IDX     = 3'd0;
	localparam logic [OP_W-1:0] OP_SET_IDX_RGB = 3'd1;
	localparam logic [OP_W-1:0] OP_SET_XY      = 3'd2;
	localparam logic [OP_W-1:0] OP_SET_XY_RGB  = 3'd3;
	localparam logic [OP_W-1:0] OP_GET         = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR       = 3'd5;
	localparam logic [OP_W-1:0] OP_STREAM      = 3'd6;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_LED_TYPE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT = 2'd2;

	// LED types.
	localparam logic [TYPE_W-1:0] LED_APA102 = 2'd0;
	localparam logic [TYPE_W-1:0] LED_WS_RGB = 2'd1;
	localparam logic [TYPE_W-1:0] LED_WS_GRB = 2'd2;
	localparam logic [TYPE_W-1:0] LED_SK6812 = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [TYPE_W-1:0] RST_LED_TYPE    = LED_WS_RGB;
	localparam logic [CFG_W-1:0]  RST_ROW_WIDTH   = 9'd16;
	localparam logic [CFG_W-1:0]  RST_PIXEL_COUNT = 9'd256;

	// Frame sections; only APA102 frames use the header and footer.
	localparam logic [SECT_W-1:0] SECT_HDR  = 2'd0;
	localparam logic [SECT_W-1:0] SECT_BODY = 2'd1;
	localparam logic [SECT_W-1:0] SECT_FTR  = 2'd2;

	// Last byte number inside one pixel (or header/footer) per LED type.
	localparam logic [SUB_W-1:0] SUB_LAST_APA = 4'd3;
	localparam logic [SUB_W-1:0] SUB_LAST_WS  = 4'd2;
	localparam logic [SUB_W-1:0] SUB_LAST_SK  = 4'd11;

	localparam logic [BRIGHT_W-1:0] BRIGHT_RGB   = 5'd7;
	localparam logic [BYTE_W-1:0]   APA_HDR_BYTE = 8'h00;
	localparam logic [BYTE_W-1:0]   APA_FTR_BYTE = 8'hFF;
	localparam logic [2:0]          APA_LEAD     = 3'b111;

	typedef struct packed {
		logic [SECT_W-1:0] sect;
		logic [SUB_W-1:0]  sub;
	} frame_sel_t;

endpackage

### design/led_strip_pixel_frame_engine.sv
// Stream passes through its output state, set by index and opcode 7 through the action state,
// get through the action state and, when in range, a read wait state; set by x,y first runs
// the bit-serial column remainder and a sum state; clear writes one store entry per cycle.
// busy is low in the done cycle, so the next item is accepted at the edge that ends it.
// Results cannot be held off by the receiver.
// After arst_n the pixel store is swept to zero with busy high;
// configuration writes are taken during the sweep.
module led_strip_pixel_frame_engine #(
	parameter int MAX_PIXELS = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [lspfe_pkg::OP_W-1:0]      opcode,
	input  logic [lspfe_pkg::IDX_W-1:0]     pixel_index,
	input  logic [lspfe_pkg::COORD_W-1:0]   coord_x,
	input  logic [lspfe_pkg::COORD_W-1:0]   coord_y,
	input  logic [lspfe_pkg::WORD_W-1:0]    color_word,
	output logic                            done,
	output logic [lspfe_pkg::COLOR_W-1:0]   pixel_color,
	output logic                            in_range,
	output logic [lspfe_pkg::BYTE_W-1:0]    wire_byte,
	output logic                            wire_last,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lspfe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lspfe_pkg::CFG_W-1:0]     cfg_data
);
	import lspfe_pkg::*;

	localparam int AW    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int CW    = $clog2(MAX_PIXELS + 1);
	localparam int TGT_W = COORD_W + CFG_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CLR  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_SUM  = 3'd3;
	localparam logic [2:0] ST_ACT  = 3'd4;
	localparam logic [2:0] ST_GETW = 3'd5;
	localparam logic [2:0] ST_SOUT = 3'd6;

	logic [2:0]          state_q;
	logic [OP_W-1:0]     op_q;
	logic [COLOR_W-1:0]  val_q;
	logic [TGT_W-1:0]    tgt_q;
	logic [COORD_W-1:0]  y_q;
	logic [TGT_W-1:0]    prod_q;
	logic [CFG_W-1:0]    col_q;
	logic [AW-1:0]       clr_q;
	logic                clr_op_q;
	logic [TYPE_W-1:0]   led_type_q;
	logic [CFG_W-1:0]    row_width_q;
	logic [CFG_W-1:0]    pixel_count_q;
	logic [SECT_W-1:0]   sect_q;
	logic [AW-1:0]       pix_q;
	logic [SUB_W-1:0]    sub_q;
	logic                done_q;
	logic [COLOR_W-1:0]  pixel_color_q;
	logic                in_range_q;
	logic [BYTE_W-1:0]   wire_byte_q;
	logic                wire_last_q;

	logic                accept;
	logic [CFG_W-1:0]    w_eff;
	logic [CW-1:0]       eff;
	logic                in_rng;
	logic                set_op;
	logic                rgb_in;
	logic [COLOR_W-1:0]  val_in;
	logic                mod_go;
	logic                mod_done;
	logic [CFG_W-1:0]    mod_rem;
	logic [CFG_W-1:0]    col_next;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [COLOR_W-1:0]  ram_wdata;
	logic [AW-1:0]       ram_raddr;
	logic [COLOR_W-1:0]  ram_rdata;
	frame_sel_t          sel;
	logic [BYTE_W-1:0]   fmt_byte;
	logic                len_zero;
	logic [SUB_W-1:0]    sub_end;
	logic                sub_last;
	logic                pix_last;
	logic [SECT_W-1:0]   nxt_sect;
	logic [AW-1:0]       nxt_pix;
	logic [SUB_W-1:0]    nxt_sub;
	logic                s_last;
	logic [BYTE_W-1:0]   s_byte;
	logic                cfg_hit;
	logic                res_fire;
	logic [COLOR_W-1:0]  res_color;
	logic                res_rng;
	logic [BYTE_W-1:0]   res_byte;
	logic                res_last;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && ((cfg_index == CFG_LED_TYPE) ||
		(cfg_index == CFG_ROW_WIDTH) || (cfg_index == CFG_PIXEL_COUNT));

	assign w_eff = (row_width_q == '0) ? CFG_W'(1) : row_width_q;
	assign eff   = (32'(pixel_count_q) > 32'(MAX_PIXELS)) ? CW'(MAX_PIXELS)
		: CW'(pixel_count_q);

	assign in_rng = tgt_q < TGT_W'(eff);
	assign set_op = (op_q == OP_SET_IDX) || (op_q == OP_SET_IDX_RGB) ||
		(op_q == OP_SET_XY) || (op_q == OP_SET_XY_RGB);

	assign rgb_in = (opcode == OP_SET_IDX_RGB) || (opcode == OP_SET_XY_RGB);
	assign val_in = rgb_in ?
		{((led_type_q == LED_APA102) ? BRIGHT_RGB : BRIGHT_W'(0)), color_word[RGB_W-1:0]}
		: color_word[COLOR_W-1:0];

	assign mod_go = accept && ((opcode == OP_SET_XY) || (opcode == OP_SET_XY_RGB));

	// Odd rows run right to left.
	assign col_next = y_q[0] ? (w_eff - CFG_W'(1) - mod_rem) : mod_rem;

	lspfe_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (mod_go),
		.dividend (coord_x),
		.divisor  (w_eff),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = tgt_q[AW-1:0];
		ram_wdata = val_q;
		if (state_q == ST_CLR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if ((state_q == ST_ACT) && set_op && in_rng) begin
			ram_we = 1'b1;
		end
	end

	// Outside the action state the read port follows the stream position, so a stream item
	// finds its pixel already read in the cycle after it is accepted.
	assign ram_raddr = (state_q == ST_ACT) ? tgt_q[AW-1:0] : pix_q;

	lspfe_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (MAX_PIXELS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign sel.sect = sect_q;
	assign sel.sub  = sub_q;

	lspfe_fmt u_fmt (
		.led_type  (led_type_q),
		.sel       (sel),
		.pixel     (ram_rdata),
		.wire_byte (fmt_byte)
	);

	assign len_zero = (led_type_q != LED_APA102) && (eff == '0);
	assign sub_end  = (led_type_q == LED_APA102) ? SUB_LAST_APA :
		(led_type_q == LED_SK6812) ? SUB_LAST_SK : SUB_LAST_WS;
	assign sub_last = (sub_q == sub_end);
	assign pix_last = ((CW'(pix_q) + CW'(1)) == eff);

	// Next frame position after one stream byte.
	always_comb begin
		nxt_sect = sect_q;
		nxt_pix  = pix_q;
		nxt_sub  = sub_q + SUB_W'(1);
		s_last   = 1'b0;
		s_byte   = fmt_byte;
		if (len_zero) begin
			nxt_sect = SECT_HDR;
			nxt_pix  = '0;
			nxt_sub  = '0;
			s_last   = 1'b1;
			s_byte   = '0;
		end else if (led_type_q == LED_APA102) begin
			if (sub_last) begin
				nxt_sub = '0;
				case (sect_q)
					SECT_HDR: begin
						nxt_pix  = '0;
						nxt_sect = (eff == '0) ? SECT_FTR : SECT_BODY;
					end
					SECT_BODY: begin
						if (pix_last) begin
							nxt_pix  = '0;
							nxt_sect = SECT_FTR;
						end else begin
							nxt_pix = pix_q + AW'(1);
						end
					end
					SECT_FTR: begin
						nxt_sect = SECT_HDR;
						nxt_pix  = '0;
						s_last   = 1'b1;
					end
					default: begin
						nxt_sect = SECT_HDR;
						nxt_pix  = '0;
					end
				endcase
			end
		end else if (sub_last) begin
			nxt_sub = '0;
			if (pix_last) begin
				nxt_sect = SECT_HDR;
				nxt_pix  = '0;
				s_last   = 1'b1;
			end else begin
				nxt_pix = pix_q + AW'(1);
			end
		end
	end

	always_comb begin
		res_fire  = 1'b0;
		res_color = '0;
		res_rng   = 1'b0;
		res_byte  = '0;
		res_last  = 1'b0;
		unique case (state_q)
			ST_CLR: begin
				res_fire = clr_op_q && (clr_q == AW'(MAX_PIXELS - 1));
			end
			ST_ACT: begin
				res_fire = !((op_q == OP_GET) && in_rng);
				res_rng  = set_op && in_rng;
			end
			ST_GETW: begin
				res_fire  = 1'b1;
				res_rng   = 1'b1;
				res_color = (led_type_q == LED_APA102) ? ram_rdata
					: {BRIGHT_W'(0), ram_rdata[RGB_W-1:0]};
			end
			ST_SOUT: begin
				res_fire = 1'b1;
				res_byte = s_byte;
				res_last = s_last;
			end
			default: begin
				res_fire = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLR;
			clr_q         <= '0;
			clr_op_q      <= 1'b0;
			led_type_q    <= RST_LED_TYPE;
			row_width_q   <= RST_ROW_WIDTH;
			pixel_count_q <= RST_PIXEL_COUNT;
			sect_q        <= SECT_HDR;
			pix_q         <= '0;
			sub_q         <= '0;
			done_q        <= 1'b0;
			pixel_color_q <= '0;
			in_range_q    <= 1'b0;
			wire_byte_q   <= '0;
			wire_last_q   <= 1'b0;
		end else begin
			done_q <= res_fire;
			if (res_fire) begin
				pixel_color_q <= res_color;
				in_range_q    <= res_rng;
				wire_byte_q   <= res_byte;
				wire_last_q   <= res_last;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (opcode) inside
							OP_SET_XY, OP_SET_XY_RGB: state_q <= ST_DIV;
							OP_CLEAR: begin
								state_q  <= ST_CLR;
								clr_q    <= '0;
								clr_op_q <= 1'b1;
							end
							OP_STREAM: state_q <= ST_SOUT;
							default:   state_q <= ST_ACT;
						endcase
					end
				end
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_PIXELS - 1)) begin
						state_q  <= ST_IDLE;
						clr_op_q <= 1'b0;
					end
				end
				ST_DIV: begin
					if (mod_done) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM:  state_q <= ST_ACT;
				ST_ACT:  state_q <= res_fire ? ST_IDLE : ST_GETW;
				ST_GETW: state_q <= ST_IDLE;
				ST_SOUT: begin
					state_q <= ST_IDLE;
					sect_q  <= nxt_sect;
					pix_q   <= nxt_pix;
					sub_q   <= nxt_sub;
				end
				default: state_q <= ST_IDLE;
			endcase

			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_LED_TYPE:    led_type_q    <= cfg_data[TYPE_W-1:0];
					CFG_ROW_WIDTH:   row_width_q   <= cfg_data;
					CFG_PIXEL_COUNT: pixel_count_q <= cfg_data;
					default:         ;
				endcase
			end
			// Any register write restarts the frame.
			if (cfg_hit) begin
				sect_q <= SECT_HDR;
				pix_q  <= '0;
				sub_q  <= '0;
			end
		end
	end

	// Operand and address registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= opcode;
			val_q <= val_in;
			tgt_q <= TGT_W'(pixel_index);
			y_q   <= coord_y;
		end else if ((state_q == ST_DIV) && mod_done) begin
			prod_q <= TGT_W'(y_q) * TGT_W'(w_eff);
			col_q  <= col_next;
		end else if (state_q == ST_SUM) begin
			tgt_q <= prod_q + TGT_W'(col_q);
		end
	end

	assign done        = done_q;
	assign pixel_color = pixel_color_q;
	assign in_range    = in_range_q;
	assign wire_byte   = wire_byte_q;
	assign wire_last   = wire_last_q;

`ifndef SYNTHESIS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done strobe held for more than one cycle");

	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !ram_we)
		else $error("pixel store written while idle");

	a_last_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(wire_last) |-> done)
		else $error("wire_last without a result");

	a_last_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		(done && wire_last) |-> ((pix_q == '0) && (sub_q == '0) && (sect_q == SECT_HDR)))
		else $error("frame position not rewound after the last byte");
`endif

endmodule

### design/lspfe_ram.sv
module lspfe_ram #(
	parameter int WIDTH = 29,
	parameter int DEPTH = 256
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/lspfe_mod.sv
module lspfe_mod (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic [lspfe_pkg::COORD_W-1:0] dividend,
	input  logic [lspfe_pkg::CFG_W-1:0]   divisor,
	output logic                          done,
	output logic [lspfe_pkg::CFG_W-1:0]   rem
);
	import lspfe_pkg::*;

	localparam int CNT_W = $clog2(COORD_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [COORD_W-1:0] dvd_q;
	logic [CFG_W-1:0]   dvs_q;
	logic [CFG_W-1:0]   rem_q;
	logic [CFG_W:0]     trial;
	logic [CFG_W-1:0]   rem_nxt;

	// Restoring remainder, one dividend bit per cycle, MSB first.
	always_comb begin
		trial = {rem_q, dvd_q[COORD_W-1]};
		if (trial >= {1'b0, dvs_q}) begin
			rem_nxt = CFG_W'(trial - {1'b0, dvs_q});
		end else begin
			rem_nxt = CFG_W'(trial);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(COORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[COORD_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

### design/lspfe_fmt.sv
module lspfe_fmt (
	input  logic [lspfe_pkg::TYPE_W-1:0]  led_type,
	input  lspfe_pkg::frame_sel_t         sel,
	input  logic [lspfe_pkg::COLOR_W-1:0] pixel,
	output logic [lspfe_pkg::BYTE_W-1:0]  wire_byte
);
	import lspfe_pkg::*;

	logic [BYTE_W-1:0]   chan_r;
	logic [BYTE_W-1:0]   chan_g;
	logic [BYTE_W-1:0]   chan_b;
	logic [BRIGHT_W-1:0] bright;
	logic [BYTE_W-1:0]   sk_chan;
	logic [1:0]          pair;
	logic [BYTE_W-1:0]   sk_byte;
	logic [BYTE_W-1:0]   apa_byte;
	logic [BYTE_W-1:0]   ws_byte;

	assign chan_b = pixel[7:0];
	assign chan_g = pixel[15:8];
	assign chan_r = pixel[23:16];
	assign bright = pixel[COLOR_W-1:RGB_W];

	// SK6812: four wire bytes per color byte, two data bits each, 0 as 1000 and 1 as 1100.
	always_comb begin
		case (sel.sub[3:2])
			2'd0:    sk_chan = chan_g;
			2'd1:    sk_chan = chan_r;
			default: sk_chan = chan_b;
		endcase
		case (sel.sub[1:0])
			2'd0:    pair = sk_chan[7:6];
			2'd1:    pair = sk_chan[5:4];
			2'd2:    pair = sk_chan[3:2];
			default: pair = sk_chan[1:0];
		endcase
		sk_byte = {1'b1, pair[1], 2'b00, 1'b1, pair[0], 2'b00};
	end

	always_comb begin
		apa_byte = APA_HDR_BYTE;
		case (sel.sect)
			SECT_BODY: begin
				case (sel.sub[1:0])
					2'd0:    apa_byte = {APA_LEAD, bright};
					2'd1:    apa_byte = chan_b;
					2'd2:    apa_byte = chan_g;
					default: apa_byte = chan_r;
				endcase
			end
			SECT_FTR: apa_byte = APA_FTR_BYTE;
			default:  apa_byte = APA_HDR_BYTE;
		endcase
	end

	always_comb begin
		case (sel.sub[1:0])
			2'd0:    ws_byte = (led_type == LED_WS_RGB) ? chan_r : chan_g;
			2'd1:    ws_byte = (led_type == LED_WS_RGB) ? chan_g : chan_r;
			default: ws_byte = chan_b;
		endcase
	end

	always_comb begin
		unique case (led_type)
			LED_APA102: wire_byte = apa_byte;
			LED_SK6812: wire_byte = sk_byte;
			default:    wire_byte = ws_byte;
		endcase
	end

endmodule
